/* rtl/core/escaped_frame_deframer_macros.svh */
// assertion macros for the escaped frame deframer
`ifndef ESCAPED_FRAME_DEFRAMER_MACROS_SVH
`define ESCAPED_FRAME_DEFRAMER_MACROS_SVH

// condition now implies consequence in the same cycle
`define EFD_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// condition now implies consequence in the next cycle
`define EFD_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

/* rtl/core/efd_pkg.sv */
// shared types and constants for the escaped frame deframer
`timescale 1ns / 1ps

package efd_pkg;

	localparam logic [7:0] SYNC_BYTE       = 8'hE0;
	localparam logic [7:0] ESC_BYTE        = 8'hD0;
	localparam logic [7:0] REMAINING_RESET = 8'hFF;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [2:0] ST_DATA    = 3'd0;
	localparam logic [2:0] ST_OK      = 3'd1;
	localparam logic [2:0] ST_BADSUM  = 3'd2;
	localparam logic [2:0] ST_STRAY   = 3'd3;
	localparam logic [2:0] ST_GARBAGE = 3'd4;

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_BODY = 2'd1,
		PH_CSUM = 2'd2
	} efd_phase_t;

	// one classified byte waiting in the queue
	typedef struct packed {
		logic [7:0] raw;
		logic       is_sync;
		logic       is_esc;
	} efd_item_t;

	// queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} efd_qstat_t;

endpackage

/* rtl/core/escaped_frame_deframer.sv */
// top level of the escaped frame deframer
`timescale 1ns / 1ps

// escaped frame deframer: takes one received serial byte per request on the
// input channel and hands out decoded frame bytes and frame status on the
// output channel. a frame opens on sync 0xe0, its first body byte is the
// length, 0xd0 escapes the next byte (taken plus one), and the raw byte after
// the body is checked against the 8-bit sum of the decoded body. sustained
// rate is one byte per clock in while the queue has room and at most one result
// per clock out; a taken byte passes through the classification queue and then
// the registered result stage. resync_on_garbage resets to 1; the user writes it
// through cfg_we/cfg_wdata while the block idles, the block does not enforce it.

`include "escaped_frame_deframer_macros.svh"

module escaped_frame_deframer #(
	parameter int QUEUE_DEPTH = efd_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	// configuration
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	// byte requests in
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	// result requests out
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] data_byte,
	output logic [2:0] status,
	output logic       last
);

	efd_pkg::efd_qstat_t qstat;
	efd_pkg::efd_item_t  push_item;
	efd_pkg::efd_item_t  head;
	logic                push;
	logic                pop;
	logic                in_take;
	logic                res_ends_frame;
	logic                res_in_frame;

	// front: tags each byte as sync, escape or plain and queues it
	efd_front u_front (
		.in_valid (in_valid),
		.rx_byte  (rx_byte),
		.in_stall (in_stall),
		.qstat    (qstat),
		.push     (push),
		.item     (push_item)
	);

	// short queue so the line side keeps flowing while results wait
	efd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	// back: frame tracking, escape decode, checksum, result register
	efd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.head      (head),
		.qstat     (qstat),
		.pop       (pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.data_byte (data_byte),
		.status    (status),
		.last      (last)
	);

	// status groups seen on the output
	assign in_take        = in_valid && !in_stall;
	assign res_ends_frame = (status == efd_pkg::ST_OK) || (status == efd_pkg::ST_BADSUM) ||
		(status == efd_pkg::ST_STRAY);
	assign res_in_frame   = (status == efd_pkg::ST_DATA) || (status == efd_pkg::ST_GARBAGE);

	// a byte taken into an empty queue always lands in the queue
	`EFD_ASSERT_NEXT(a_push_fills, in_take && qstat.empty, !qstat.empty, "taken byte lost")
	// frame end and abort results close the frame
	`EFD_ASSERT_NOW(a_end_last, out_valid && res_ends_frame, last, "frame end without last")
	// data and garbage results never close a frame
	`EFD_ASSERT_NOW(a_data_not_last, out_valid && res_in_frame, !last, "last on data or garbage")

endmodule

/* rtl/core/efd_front.sv */
// front end: takes received bytes and tags sync and escape codes
`timescale 1ns / 1ps

module efd_front (
	input  logic              in_valid,
	input  logic [7:0]        rx_byte,
	output logic              in_stall,
	input  efd_pkg::efd_qstat_t qstat,
	output logic              push,
	output efd_pkg::efd_item_t  item
);

	assign in_stall = qstat.full;
	assign push     = in_valid && !qstat.full;

	always_comb begin
		item.raw     = rx_byte;
		item.is_sync = (rx_byte == efd_pkg::SYNC_BYTE);
		item.is_esc  = (rx_byte == efd_pkg::ESC_BYTE);
	end

endmodule

/* rtl/core/efd_queue.sv */
// short fifo of classified bytes between front and back
`timescale 1ns / 1ps

module efd_queue #(
	parameter int DEPTH = efd_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  efd_pkg::efd_item_t  push_item,
	input  logic                pop,
	output efd_pkg::efd_item_t  head,
	output efd_pkg::efd_qstat_t qstat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	efd_pkg::efd_item_t slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head        = slot_q[rd_ptr_q];
	assign qstat.full  = (count_q == FULL_CNT);
	assign qstat.empty = (count_q == '0);

endmodule

/* rtl/core/efd_back.sv */
// back end: frame state machine, checksum and result register
`timescale 1ns / 1ps

module efd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	input  efd_pkg::efd_item_t  head,
	input  efd_pkg::efd_qstat_t qstat,
	output logic                pop,
	input  logic                out_stall,
	output logic                out_valid,
	output logic [7:0]          data_byte,
	output logic [2:0]          status,
	output logic                last
);

	efd_pkg::efd_phase_t phase_q, phase_d;
	logic       resync_q;
	logic       esc_q, esc_d;
	logic       len_q, len_d;
	logic [7:0] rem_q, rem_d;
	logic [7:0] sum_q, sum_d;

	logic       res_valid;
	logic [7:0] res_data;
	logic [2:0] res_status;
	logic       res_last;

	logic [7:0] dec_byte;
	logic [7:0] sum_add;
	logic [7:0] rem_body;
	logic       go;

	// head consumed when the result slot is free or drains this cycle
	assign go  = !qstat.empty && (!out_valid || !out_stall);
	assign pop = go;

	assign dec_byte = esc_q ? head.raw + 8'd1 : head.raw;
	assign sum_add  = sum_q + dec_byte;

	always_comb begin
		if (len_q) begin
			rem_body = (dec_byte == 8'd0) ? 8'd0 : dec_byte - 8'd1;
		end else if (rem_q != 8'd0) begin
			rem_body = rem_q - 8'd1;
		end else begin
			rem_body = rem_q;
		end
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		esc_d   = esc_q;
		len_d   = len_q;
		rem_d   = rem_q;
		sum_d   = sum_q;
		unique case (phase_q)
			efd_pkg::PH_BODY: begin
				if (head.is_esc) begin
					esc_d = 1'b1;
				end else if (!esc_q && head.is_sync) begin
					phase_d = efd_pkg::PH_HUNT;
					esc_d   = 1'b0;
					len_d   = 1'b1;
					rem_d   = efd_pkg::REMAINING_RESET;
					sum_d   = 8'd0;
				end else begin
					esc_d = 1'b0;
					len_d = 1'b0;
					rem_d = rem_body;
					sum_d = sum_add;
					if (rem_body == 8'd0) begin
						phase_d = efd_pkg::PH_CSUM;
					end
				end
			end
			efd_pkg::PH_CSUM: begin
				phase_d = efd_pkg::PH_HUNT;
				esc_d   = 1'b0;
				len_d   = 1'b1;
				rem_d   = efd_pkg::REMAINING_RESET;
				sum_d   = 8'd0;
			end
			default: begin
				phase_d = head.is_sync ? efd_pkg::PH_BODY : efd_pkg::PH_HUNT;
				esc_d   = 1'b0;
				len_d   = 1'b1;
				rem_d   = efd_pkg::REMAINING_RESET;
				sum_d   = 8'd0;
			end
		endcase
	end

	// result of the head byte
	always_comb begin
		res_valid  = 1'b0;
		res_data   = head.raw;
		res_status = efd_pkg::ST_DATA;
		res_last   = 1'b0;
		unique case (phase_q)
			efd_pkg::PH_BODY: begin
				if (head.is_esc) begin
					res_valid = 1'b0;
				end else if (!esc_q && head.is_sync) begin
					res_valid  = 1'b1;
					res_status = efd_pkg::ST_STRAY;
					res_last   = 1'b1;
				end else begin
					res_valid = 1'b1;
					res_data  = dec_byte;
				end
			end
			efd_pkg::PH_CSUM: begin
				res_valid  = 1'b1;
				res_status = (head.raw == sum_q) ? efd_pkg::ST_OK : efd_pkg::ST_BADSUM;
				res_last   = 1'b1;
			end
			default: begin
				res_valid  = !head.is_sync && !resync_q;
				res_status = efd_pkg::ST_GARBAGE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resync_q  <= 1'b1;
			phase_q   <= efd_pkg::PH_HUNT;
			esc_q     <= 1'b0;
			len_q     <= 1'b1;
			rem_q     <= efd_pkg::REMAINING_RESET;
			sum_q     <= 8'd0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				resync_q <= cfg_wdata;
			end
			if (go) begin
				phase_q   <= phase_d;
				esc_q     <= esc_d;
				len_q     <= len_d;
				rem_q     <= rem_d;
				sum_q     <= sum_d;
				out_valid <= res_valid;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && res_valid) begin
			data_byte <= res_data;
			status    <= res_status;
			last      <= res_last;
		end
	end

endmodule
